FILE: rtl/core/aft_pkg.sv
// ============================================================================
// aft_pkg: shared types and constants for the address frequency table
// Field widths, status codes, mode codes, and the stored entry layout.
// ============================================================================
package aft_pkg;

    localparam int ADDR_W    = 32;
    localparam int CNT_W     = 32;
    localparam int STATUS_W  = 3;
    localparam int ENTRIES_W = 9;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_HIT   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NEW   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_POP   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd4;

    // request modes
    localparam logic MODE_COUNT = 1'b0;
    localparam logic MODE_POP   = 1'b1;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [CNT_W-1:0]  cnt;
    } entry_t;

    typedef struct packed {
        logic             addr_eq;
        logic             cnt_gt;
        logic [CNT_W-1:0] cnt_inc;
    } cmp_res_t;

endpackage

FILE: rtl/core/aft_if.sv
// ============================================================================
// aft_if: valid/ready channels of the address frequency table
// Request channel (mode, address) and result channel (status, address, count).
// ============================================================================
interface aft_cmd_if;
    logic                       valid;
    logic                       ready;
    logic                       mode;
    logic [aft_pkg::ADDR_W-1:0] ip_addr;

    modport source (output valid, output mode, output ip_addr, input ready);
    modport sink   (input valid, input mode, input ip_addr, output ready);
endinterface

interface aft_res_if;
    logic                          valid;
    logic                          ready;
    logic [aft_pkg::STATUS_W-1:0]  status;
    logic [aft_pkg::ADDR_W-1:0]    top_address;
    logic [aft_pkg::CNT_W-1:0]     count_value;
    logic [aft_pkg::ENTRIES_W-1:0] entries;

    modport source (output valid, output status, output top_address,
                    output count_value, output entries, input ready);
    modport sink   (input valid, input status, input top_address,
                    input count_value, input entries, output ready);
endinterface

FILE: rtl/core/aft_store.sv
// ============================================================================
// aft_store: entry memory
// One write port and one read port with registered read data.
// ============================================================================
module aft_store #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic            clk,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  aft_pkg::entry_t wr_data,
    input  logic            rd_en,
    input  logic [AW-1:0]   rd_addr,
    output aft_pkg::entry_t rd_data
);
    import aft_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/aft_cmp.sv
// ============================================================================
// aft_cmp: shared compare unit
// Address match, count ordering and saturating count increment.
// ============================================================================
module aft_cmp (
    input  aft_pkg::entry_t             cur,
    input  logic [aft_pkg::ADDR_W-1:0]  key,
    input  logic [aft_pkg::CNT_W-1:0]   best_cnt,
    output aft_pkg::cmp_res_t           res
);
    import aft_pkg::*;

    always_comb
    begin
        res.addr_eq = (cur.addr == key);
        res.cnt_gt  = (cur.cnt > best_cnt);
        res.cnt_inc = (cur.cnt == CNT_MAX) ? CNT_MAX : cur.cnt + CNT_W'(1);
    end

endmodule

FILE: rtl/core/address_frequency_table_core.sv
// ============================================================================
// address_frequency_table_core: address occurrence table with max-count pop
// Counts 32-bit addresses in insertion order and pops the most frequent one.
// ============================================================================
//
// The block keeps up to TABLE_DEPTH addresses with a 32-bit saturating count
// each, in the order they first arrived, in a single-port-write, single-port-
// read memory. A count request (mode 0) walks the table one entry per cycle
// through the shared compare unit; a hit bumps that entry's count, a miss
// appends a new entry with count 1 or reports the table full. A pop request
// (mode 1) walks the whole table for the largest count (earliest entry wins a
// tie), then moves every later entry up one place, one per cycle. The block
// takes one request at a time: a count request walks the table until the hit,
// or to the end on a miss; a pop walks the whole table and then the entries
// after the popped one. Each request gives exactly one result transaction,
// held in an output register so the next request can be accepted while the
// result waits. The memory needs no clearing after reset: only entries below
// the fill count are ever read.
//
module address_frequency_table_core #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic     clk,
    input  logic     rst_n,
    aft_cmd_if.sink  cmd,
    aft_res_if.source res
);
    import aft_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int FW = $clog2(TABLE_DEPTH + 1);
    localparam logic [FW-1:0] FILL_MAX = FW'(TABLE_DEPTH);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    // sequencer state
    logic [1:0]    state_reg, state_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [FW-1:0] idx_reg, idx_next;      // next entry to read
    logic [AW-1:0] pidx_reg, pidx_next;    // entry whose data is on rd_data
    logic          pend_reg, pend_next;    // rd_data holds a live read
    logic          out_valid_reg, out_valid_next;

    // request and working payload
    logic              mode_reg, mode_next;
    logic [ADDR_W-1:0] key_reg, key_next;
    logic [AW-1:0]     best_reg, best_next;
    logic [ADDR_W-1:0] best_addr_reg, best_addr_next;
    logic [CNT_W-1:0]  best_cnt_reg, best_cnt_next;

    // pending result and output register
    logic [STATUS_W-1:0] rs_status_reg, rs_status_next;
    logic [ADDR_W-1:0]   rs_addr_reg, rs_addr_next;
    logic [CNT_W-1:0]    rs_cnt_reg, rs_cnt_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [ADDR_W-1:0]   out_addr_reg, out_addr_next;
    logic [CNT_W-1:0]    out_cnt_reg, out_cnt_next;
    logic [ENTRIES_W-1:0] out_entries_reg, out_entries_next;

    // memory and compare unit hookup
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    entry_t        wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    entry_t        rd_data;
    cmp_res_t      cmp;

    aft_store #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    aft_cmp u_cmp (
        .cur      (rd_data),
        .key      (key_reg),
        .best_cnt (best_cnt_reg),
        .res      (cmp)
    );

    assign cmd.ready       = (state_reg == S_IDLE);
    assign res.valid       = out_valid_reg;
    assign res.status      = out_status_reg;
    assign res.top_address = out_addr_reg;
    assign res.count_value = out_cnt_reg;
    assign res.entries     = out_entries_reg;

    always_comb
    begin
        state_next       = state_reg;
        fill_next        = fill_reg;
        idx_next         = idx_reg;
        pidx_next        = pidx_reg;
        pend_next        = pend_reg;
        mode_next        = mode_reg;
        key_next         = key_reg;
        best_next        = best_reg;
        best_addr_next   = best_addr_reg;
        best_cnt_next    = best_cnt_reg;
        rs_status_next   = rs_status_reg;
        rs_addr_next     = rs_addr_reg;
        rs_cnt_next      = rs_cnt_reg;
        out_status_next  = out_status_reg;
        out_addr_next    = out_addr_reg;
        out_cnt_next     = out_cnt_reg;
        out_entries_next = out_entries_reg;
        out_valid_next   = out_valid_reg;

        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = '0;
        rd_en   = 1'b0;
        rd_addr = idx_reg[AW-1:0];

        // drop the result once the sink takes it
        if (out_valid_reg && res.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    mode_next  = cmd.mode;
                    key_next   = cmd.ip_addr;
                    idx_next   = '0;
                    pend_next  = 1'b0;
                    best_next  = '0;
                    state_next = S_SCAN;
                end
            end

            S_SCAN:
            begin
                if (pend_reg && mode_reg == MODE_COUNT && cmp.addr_eq)
                begin
                    // hit: bump the count in place and stop the walk
                    wr_en          = 1'b1;
                    wr_addr        = pidx_reg;
                    wr_data.addr   = key_reg;
                    wr_data.cnt    = cmp.cnt_inc;
                    rs_status_next = ST_HIT;
                    rs_addr_next   = key_reg;
                    rs_cnt_next    = cmp.cnt_inc;
                    pend_next      = 1'b0;
                    state_next     = S_DONE;
                end
                else
                begin
                    // track the first strictly larger count
                    if (pend_reg && mode_reg == MODE_POP &&
                        (pidx_reg == '0 || cmp.cnt_gt))
                    begin
                        best_next      = pidx_reg;
                        best_addr_next = rd_data.addr;
                        best_cnt_next  = rd_data.cnt;
                    end

                    if (idx_reg < fill_reg)
                    begin
                        rd_en     = 1'b1;
                        pidx_next = idx_reg[AW-1:0];
                        pend_next = 1'b1;
                        idx_next  = idx_reg + FW'(1);
                    end
                    else
                    begin
                        pend_next = 1'b0;
                        if (!pend_reg)
                        begin
                            if (mode_reg == MODE_COUNT)
                            begin
                                state_next   = S_DONE;
                                rs_addr_next = key_reg;
                                if (fill_reg == FILL_MAX)
                                begin
                                    rs_status_next = ST_FULL;
                                    rs_cnt_next    = '0;
                                end
                                else
                                begin
                                    // miss: append a new entry at the tail
                                    wr_en          = 1'b1;
                                    wr_addr        = fill_reg[AW-1:0];
                                    wr_data.addr   = key_reg;
                                    wr_data.cnt    = CNT_W'(1);
                                    fill_next      = fill_reg + FW'(1);
                                    rs_status_next = ST_NEW;
                                    rs_cnt_next    = CNT_W'(1);
                                end
                            end
                            else if (fill_reg == '0)
                            begin
                                rs_status_next = ST_EMPTY;
                                rs_addr_next   = '0;
                                rs_cnt_next    = '0;
                                state_next     = S_DONE;
                            end
                            else
                            begin
                                rs_status_next = ST_POP;
                                rs_addr_next   = best_addr_reg;
                                rs_cnt_next    = best_cnt_reg;
                                idx_next       = FW'(best_reg) + FW'(1);
                                state_next     = S_SHIFT;
                            end
                        end
                    end
                end
            end

            S_SHIFT:
            begin
                // move each later entry up one place to close the gap
                if (pend_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = pidx_reg - AW'(1);
                    wr_data = rd_data;
                end

                if (idx_reg < fill_reg)
                begin
                    rd_en     = 1'b1;
                    pidx_next = idx_reg[AW-1:0];
                    pend_next = 1'b1;
                    idx_next  = idx_reg + FW'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        fill_next  = fill_reg - FW'(1);
                        state_next = S_DONE;
                    end
                end
            end

            S_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || res.ready)
                begin
                    out_valid_next   = 1'b1;
                    out_status_next  = rs_status_reg;
                    out_addr_next    = rs_addr_reg;
                    out_cnt_next     = rs_cnt_reg;
                    out_entries_next = ENTRIES_W'(fill_reg);
                    state_next       = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            idx_reg       <= '0;
            pidx_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            idx_reg       <= idx_next;
            pidx_reg      <= pidx_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg        <= mode_next;
        key_reg         <= key_next;
        best_reg        <= best_next;
        best_addr_reg   <= best_addr_next;
        best_cnt_reg    <= best_cnt_next;
        rs_status_reg   <= rs_status_next;
        rs_addr_reg     <= rs_addr_next;
        rs_cnt_reg      <= rs_cnt_next;
        out_status_reg  <= out_status_next;
        out_addr_reg    <= out_addr_next;
        out_cnt_reg     <= out_cnt_next;
        out_entries_reg <= out_entries_next;
    end

endmodule

FILE: dv/address_frequency_table_core_test.sv
// ============================================================================
// address_frequency_table_core_test: self-checking bench for the frequency table
// Sends count and pop requests with random gaps and back-pressure. Keeps a
// local model of the table, predicts every result from it, and compares each
// result transaction field by field against the oldest prediction.
// ============================================================================
module address_frequency_table_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    import aft_pkg::*;

    localparam int TABLE_DEPTH  = 256;
    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 12;
    // A pop on a full table walks the table, then up to all of it again, so allow two passes plus margin
    localparam int DRAIN_CYCLES = 2 * TABLE_DEPTH + 16;
    localparam int HOLD_CYCLES  = 2500;
    localparam int CYCLE_LIMIT  = 4_000_000;
    localparam int MAX_REPORTS  = 10;

    typedef struct {
        logic              mode;
        logic [ADDR_W-1:0] addr;
    } table_req_t;

    typedef struct {
        logic [STATUS_W-1:0]  status;
        logic [ADDR_W-1:0]    top_address;
        logic [CNT_W-1:0]     count_value;
        logic [ENTRIES_W-1:0] entries;
    } table_result_t;

    logic clk;
    logic rst_n;

    aft_cmd_if cmd_ch ();
    aft_res_if res_ch ();

    address_frequency_table_core #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch)
    );

    // ------------------------------------------------------------------------
    // Local copy of the table: addresses and counts in arrival order
    // ------------------------------------------------------------------------
    logic [ADDR_W-1:0] tbl_addr [TABLE_DEPTH];
    logic [CNT_W-1:0]  tbl_cnt  [TABLE_DEPTH];
    int                tbl_fill;
    int                peak_fill;

    table_req_t        pending_reqs [$];
    table_result_t     expected_results [$];
    logic [ADDR_W-1:0] addr_pool [$];

    int  reqs_issued;
    int  results_done;
    int  error_cnt;
    int  stall_cycles;
    int  status_tally [5];
    int  cycle_cnt;
    int  send_idle_pct;
    int  recv_idle_pct;
    int  holds_asked;
    int  holds_done;
    int  hold_left;
    logic req_taken;

    // Apply one request to the local table and return the result it produces.
    // Count: hit bumps the count (saturating), miss appends or reports full.
    // Pop: highest count wins, earliest entry on a tie; later entries move up.
    function automatic table_result_t apply_request(table_req_t rq);
        table_result_t r;
        int            hit_at;
        int            best;
        hit_at = -1;
        best   = 0;
        if (rq.mode == MODE_COUNT) begin
            r.top_address = rq.addr;
            for (int i = 0; i < tbl_fill; i++)
            begin
                if (hit_at < 0 && tbl_addr[i] == rq.addr)
                    hit_at = i;
            end
            if (hit_at >= 0) begin
                if (tbl_cnt[hit_at] != CNT_MAX)
                    tbl_cnt[hit_at] = tbl_cnt[hit_at] + 1'b1;
                r.status      = ST_HIT;
                r.count_value = tbl_cnt[hit_at];
            end else if (tbl_fill >= TABLE_DEPTH) begin
                r.status      = ST_FULL;
                r.count_value = '0;
            end else begin
                tbl_addr[tbl_fill] = rq.addr;
                tbl_cnt[tbl_fill]  = 1;
                tbl_fill++;
                r.status      = ST_NEW;
                r.count_value = 1;
            end
        end else if (tbl_fill == 0) begin
            r.status      = ST_EMPTY;
            r.top_address = '0;
            r.count_value = '0;
        end else begin
            for (int i = 1; i < tbl_fill; i++)
            begin
                if (tbl_cnt[i] > tbl_cnt[best])
                    best = i;
            end
            r.status      = ST_POP;
            r.top_address = tbl_addr[best];
            r.count_value = tbl_cnt[best];
            for (int i = best; i + 1 < tbl_fill; i++)
            begin
                tbl_addr[i] = tbl_addr[i+1];
                tbl_cnt[i]  = tbl_cnt[i+1];
            end
            tbl_fill--;
        end
        if (tbl_fill > peak_fill)
            peak_fill = tbl_fill;
        r.entries = tbl_fill[ENTRIES_W-1:0];
        return r;
    endfunction

    task automatic flag_error(string what, logic [31:0] want, logic [31:0] got);
        error_cnt++;
        if (error_cnt <= MAX_REPORTS)
            $display("[%0t] mismatch on %s: expected %h, got %h", $time, what, want, got);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic push_req(logic mode, logic [ADDR_W-1:0] addr);
        table_req_t rq;
        rq.mode = mode;
        rq.addr = addr;
        pending_reqs.push_back(rq);
        reqs_issued++;
    endtask

    // Queue a random mix. Pops take pop_pct percent; of the counts, fresh_pct
    // percent bring a new random address, the rest revisit the pool with a bias
    // toward a small hot set so that counts climb and ties show up.
    task automatic queue_mix(int n, int pop_pct, int fresh_pct);
        logic [ADDR_W-1:0] addr;
        int unsigned       span;
        repeat (n)
        begin
            addr = $urandom();
            if ($urandom_range(99) < pop_pct) begin
                // the address field is don't-care in pop mode; keep it random
                push_req(MODE_POP, addr);
            end else begin
                if (addr_pool.size() == 0 || $urandom_range(99) < fresh_pct) begin
                    addr_pool.push_back(addr);
                end else begin
                    span = addr_pool.size() - 1;
                    if ($urandom_range(1) == 0 && span > 11)
                        span = 11;
                    addr = addr_pool[$urandom_range(span)];
                end
                push_req(MODE_COUNT, addr);
            end
        end
    endtask

    // Hold until every queued request has come back as a checked result
    task automatic wait_drained();
        while (results_done < reqs_issued)
            @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Request driver: advance to the next pending item only once the current
    // transaction has been taken; otherwise hold valid and payload steady.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        table_req_t next_rq;
        if (!rst_n) begin
            cmd_ch.valid <= 1'b0;
        end else if (!cmd_ch.valid || req_taken) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_rq = pending_reqs.pop_front();
                cmd_ch.mode    <= next_rq.mode;
                cmd_ch.ip_addr <= next_rq.addr;
                cmd_ch.valid   <= 1'b1;
            end else begin
                cmd_ch.valid <= 1'b0;
            end
        end
    end

    // Record accepted requests and predict their results at the accepting edge
    always @(posedge clk)
    begin
        table_req_t taken;
        req_taken <= rst_n && cmd_ch.valid && cmd_ch.ready;
        if (rst_n && cmd_ch.valid) begin
            if (cmd_ch.ready) begin
                taken.mode = cmd_ch.mode;
                taken.addr = cmd_ch.ip_addr;
                expected_results.push_back(apply_request(taken));
            end else begin
                stall_cycles++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result receiver: random back-pressure, plus long hold-offs on request so
    // that the block's output register fills and the request side stalls.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n) begin
            res_ch.ready <= 1'b0;
        end else if (hold_left != 0) begin
            res_ch.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else if (holds_done != holds_asked) begin
            holds_done   <= holds_done + 1;
            hold_left    <= HOLD_CYCLES;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Compare each result transaction with the oldest prediction
    always @(posedge clk)
    begin
        table_result_t want;
        if (rst_n && res_ch.valid && res_ch.ready) begin
            if (res_ch.status < 5)
                status_tally[res_ch.status]++;
            if (expected_results.size() == 0) begin
                flag_error("unexpected result, status", '0, 32'(res_ch.status));
            end else begin
                want = expected_results.pop_front();
                results_done++;
                if (res_ch.status !== want.status)
                    flag_error("status", 32'(want.status), 32'(res_ch.status));
                if (res_ch.top_address !== want.top_address)
                    flag_error("top_address", want.top_address, res_ch.top_address);
                if (res_ch.count_value !== want.count_value)
                    flag_error("count_value", want.count_value, res_ch.count_value);
                if (res_ch.entries !== want.entries)
                    flag_error("entries", 32'(want.entries), 32'(res_ch.entries));
            end
        end
    end

    // Watchdog: a hang anywhere ends the run as a failure
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d of %0d results checked",
                     cycle_cnt, results_done, reqs_issued);
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n          = 1'b0;
        cmd_ch.valid   = 1'b0;
        cmd_ch.mode    = MODE_COUNT;
        cmd_ch.ip_addr = '0;
        res_ch.ready   = 1'b0;
        req_taken      = 1'b0;
        tbl_fill       = 0;
        peak_fill      = 0;
        reqs_issued    = 0;
        results_done   = 0;
        error_cnt      = 0;
        stall_cycles   = 0;
        cycle_cnt      = 0;
        holds_asked    = 0;
        holds_done     = 0;
        hold_left      = 0;
        send_idle_pct  = 28;
        recv_idle_pct  = 87;
        foreach (status_tally[i])
            status_tally[i] = 0;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: pop on an empty table, hits at both address extremes, a
        // clear winner, ties resolved to the earliest entry, drain back to
        // empty, and re-adding an address already popped.
        push_req(MODE_POP,   32'hFFFF_FFFF);
        push_req(MODE_COUNT, 32'h0000_0000);
        push_req(MODE_COUNT, 32'hFFFF_FFFF);
        push_req(MODE_COUNT, 32'hFFFF_FFFF);
        push_req(MODE_COUNT, 32'h0000_0000);
        push_req(MODE_COUNT, 32'hAAAA_AAAA);
        push_req(MODE_COUNT, 32'h5555_5555);
        push_req(MODE_COUNT, 32'h5555_5555);
        push_req(MODE_COUNT, 32'h5555_5555);
        push_req(MODE_POP,   32'h0000_0000);
        push_req(MODE_POP,   32'h1234_5678);
        push_req(MODE_POP,   32'hFFFF_FFFF);
        push_req(MODE_COUNT, 32'h8000_0000);
        push_req(MODE_COUNT, 32'h0000_0001);
        push_req(MODE_COUNT, 32'h0000_0001);
        push_req(MODE_COUNT, 32'hAAAA_AAAA);
        push_req(MODE_POP,   32'h0000_0000);
        push_req(MODE_COUNT, 32'h8000_0000);
        push_req(MODE_POP,   32'h0000_0000);
        push_req(MODE_POP,   32'h0000_0000);
        push_req(MODE_POP,   32'h0000_0000);
        push_req(MODE_COUNT, 32'h0000_0000);
        push_req(MODE_POP,   32'hFFFF_FFFF);
        wait_drained();

        // Phase 1: sender mostly busy, receiver mostly stalled.
        // Churn a small table, then fill it past capacity to hit the full drop.
        queue_mix(120, 25, 30);
        queue_mix(300, 0, 95);
        wait_drained();

        // Phase 2: sender mostly idle, receiver mostly ready.
        // Pop from a full table, drain it, then pop it empty a few times.
        send_idle_pct = 87;
        recv_idle_pct = 28;
        queue_mix(60, 60, 10);
        queue_mix(250, 75, 30);
        queue_mix(90, 100, 0);
        wait_drained();

        // Phase 3: no idling, with one long receiver hold-off to back up the block
        send_idle_pct = 0;
        recv_idle_pct = 0;
        holds_asked   = holds_asked + 1;
        queue_mix(250, 35, 40);
        wait_drained();

        // Catch any stray result after the last expected one
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (expected_results.size() != 0)
            flag_error("results still outstanding", 32'd0, expected_results.size());

        $display("Checked %0d results: %0d hits, %0d new, %0d full drops, %0d pops, %0d empty",
                 results_done, status_tally[ST_HIT], status_tally[ST_NEW],
                 status_tally[ST_FULL], status_tally[ST_POP], status_tally[ST_EMPTY]);
        $display("Peak fill %0d of %0d, request side stalled %0d cycles, %0d errors",
                 peak_fill, TABLE_DEPTH, stall_cycles, error_cnt);
        if (error_cnt == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
